/* rtl/particle_pool_update_top_defines.svh */
// Assertion macros for the particle pool checker
`ifndef PARTICLE_POOL_UPDATE_TOP_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_TOP_DEFINES_SVH

// assert that a implies b on the same edge
`define PPU_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// assert that a implies b on the next edge
`define PPU_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

/* rtl/ppu_pkg.sv */
`timescale 1ns / 1ps
package ppu_pkg;
    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_GX   = 2'd0,
        CFG_GY   = 2'd1,
        CFG_GZ   = 2'd2,
        CFG_DRAG = 2'd3
    } cfg_idx_t;

    localparam logic [30:0] MIN_LIFE = 31'd7;
    localparam logic [30:0] AGE_MAX  = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        lifetime;
        logic signed [31:0] start_rotation;
        logic signed [31:0] angular_rate;
        logic [15:0]        time_step;
    } in_word_t;

    typedef struct packed {
        logic [8:0]         alive_count;
        logic               spawn_dropped;
        logic               read_valid;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic signed [31:0] out_rotation;
        logic [30:0]        out_age;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_word_t;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] ax, ay, az;
        logic signed [31:0] rot;
        logic signed [31:0] rate;
        logic [30:0]        age;
        logic [30:0]        life;
        logic [30:0]        drg;
    } part_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_AGE,
        ST_MOVE,
        ST_VEL,
        ST_DAMP,
        ST_POS,
        ST_OUT
    } state_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            return -32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // floor(a*b/65536); arithmetic shift is floor for two's complement
    function automatic logic signed [32:0] mulq(input logic signed [31:0] a,
                                                input logic [16:0] b);
        logic signed [49:0] p;
        p = a * $signed({1'b0, b});
        return p[48:16];
    endfunction
endpackage

/* rtl/ppu_if.sv */
`timescale 1ns / 1ps
interface ppu_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/particle_pool_update_top.sv */
`timescale 1ns / 1ps
// Particle pool with Euler update. Spawn, read and unknown operations go
// through ST_OUT to the output register. A step takes each surviving
// particle through ST_RD, ST_AGE, ST_VEL, ST_DAMP and ST_POS, and each removed
// one through ST_RD, ST_AGE and ST_MOVE. These steps are set by the particle
// memory (one read, one write-back) and by the velocity, damping and position
// multiplies, which run in separate stages. One item is in work at a time; the
// result sits in an output register; the next item is taken once delivered.
module particle_pool_update_top
    import ppu_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  logic    clk,
    input  logic    rst_n,
    ppu_if.sink     in_ch,
    ppu_if.source   out_ch,
    ppu_if.sink     cfg
);
    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int SW = (CW > 8) ? CW : 8;

    part_t mem [POOL_SIZE];
    part_t rd_q;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    part_t         wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_q <= mem[raddr];
    end

    logic signed [31:0] gx_reg, gy_reg, gz_reg;
    logic [30:0]        drag_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg <= '0; gy_reg <= '0; gz_reg <= '0; drag_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.data.index))
                CFG_GX:   gx_reg <= cfg.data.data;
                CFG_GY:   gy_reg <= cfg.data.data;
                CFG_GZ:   gz_reg <= cfg.data.data;
                CFG_DRAG: drag_reg <= cfg.data.data[30:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    in_word_t  item_reg, item_next;
    part_t     p_reg, p_next;
    logic [16:0] f_reg, f_next;
    out_word_t res_reg, res_next;
    logic      ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        p_reg    <= p_next;
        f_reg    <= f_next;
        res_reg  <= res_next;
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = res_reg;

    logic [31:0] age_sum;
    logic [46:0] dd;
    logic [15:0] dt;
    logic [SW-1:0] slot_ext, cnt_ext;
    assign dt = item_reg.time_step;
    assign age_sum = {1'b0, rd_q.age} + {16'd0, dt};
    assign dd = p_reg.drg * dt;
    assign slot_ext = SW'(in_ch.data.slot);
    assign cnt_ext  = SW'(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        item_next  = item_reg;
        p_next     = p_reg;
        f_next     = f_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        we    = 1'b0;
        re    = 1'b0;
        waddr = idx_reg[AW-1:0];
        raddr = idx_reg[AW-1:0];
        wdata = p_reg;
        if (out_ch.valid && out_ch.ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    item_next = in_ch.data;
                    res_next  = '0;
                    idx_next  = '0;
                    unique case (in_ch.data.operation)
                        OP_SPAWN:
                        begin
                            if (cnt_reg >= CW'(POOL_SIZE))
                                res_next.spawn_dropped = 1'b1;
                            else
                            begin
                                wdata.px = in_ch.data.pos_x;
                                wdata.py = in_ch.data.pos_y;
                                wdata.pz = in_ch.data.pos_z;
                                wdata.vx = in_ch.data.vel_x;
                                wdata.vy = in_ch.data.vel_y;
                                wdata.vz = in_ch.data.vel_z;
                                wdata.ax = gx_reg;
                                wdata.ay = gy_reg;
                                wdata.az = gz_reg;
                                wdata.rot  = in_ch.data.start_rotation;
                                wdata.rate = in_ch.data.angular_rate;
                                wdata.age  = '0;
                                wdata.life = (in_ch.data.lifetime < MIN_LIFE) ?
                                             MIN_LIFE : in_ch.data.lifetime;
                                wdata.drg  = drag_reg;
                                waddr = cnt_reg[AW-1:0];
                                we = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            state_next = ST_OUT;
                        end
                        OP_STEP:
                            state_next = ST_RD;
                        OP_READ:
                        begin
                            if (slot_ext < cnt_ext)
                            begin
                                raddr = in_ch.data.slot[AW-1:0];
                                re = 1'b1;
                                res_next.read_valid = 1'b1;
                            end
                            state_next = ST_OUT;
                        end
                        default:
                            state_next = ST_OUT;
                    endcase
                end
            end
            ST_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    re = 1'b1;
                    state_next = ST_AGE;
                end
                else
                    state_next = ST_OUT;
            end
            ST_AGE:
            begin
                p_next = rd_q;
                p_next.age = age_sum[31] ? AGE_MAX : age_sum[30:0];
                if (p_next.age >= rd_q.life)
                begin
                    // swap-remove: pull the last live slot in, revisit this slot
                    cnt_next = cnt_reg - 1'b1;
                    raddr = cnt_next[AW-1:0];
                    re = 1'b1;
                    state_next = ST_MOVE;
                end
                else
                    state_next = ST_VEL;
            end
            ST_MOVE:
            begin
                we = 1'b1;
                wdata = rd_q;
                state_next = ST_RD;
            end
            ST_VEL:
            begin
                p_next.vx = sat32(34'(p_reg.vx) + 34'(mulq(p_reg.ax, {1'b0, dt})));
                p_next.vy = sat32(34'(p_reg.vy) + 34'(mulq(p_reg.ay, {1'b0, dt})));
                p_next.vz = sat32(34'(p_reg.vz) + 34'(mulq(p_reg.az, {1'b0, dt})));
                p_next.rot = sat32(34'(p_reg.rot) + 34'(mulq(p_reg.rate, {1'b0, dt})));
                f_next = (dd[46:16] >= 31'd65536) ? 17'd0 :
                         17'd65536 - 17'(dd[46:16]);
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                p_next.vx = sat32(34'(mulq(p_reg.vx, f_reg)));
                p_next.vy = sat32(34'(mulq(p_reg.vy, f_reg)));
                p_next.vz = sat32(34'(mulq(p_reg.vz, f_reg)));
                state_next = ST_POS;
            end
            ST_POS:
            begin
                wdata.px = sat32(34'(p_reg.px) + 34'(mulq(p_reg.vx, {1'b0, dt})));
                wdata.py = sat32(34'(p_reg.py) + 34'(mulq(p_reg.vy, {1'b0, dt})));
                wdata.pz = sat32(34'(p_reg.pz) + 34'(mulq(p_reg.vz, {1'b0, dt})));
                we = 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = ST_RD;
            end
            ST_OUT:
            begin
                res_next.alive_count = 9'(cnt_reg);
                if (res_reg.read_valid)
                begin
                    res_next.out_pos_x = rd_q.px;
                    res_next.out_pos_y = rd_q.py;
                    res_next.out_pos_z = rd_q.pz;
                    res_next.out_vel_x = rd_q.vx;
                    res_next.out_vel_y = rd_q.vy;
                    res_next.out_vel_z = rd_q.vz;
                    res_next.out_rotation = rd_q.rot;
                    res_next.out_age = rd_q.age;
                end
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

/* rtl/ppu_checker.sv */
`timescale 1ns / 1ps
`include "particle_pool_update_top_defines.svh"
module ppu_checker
    import ppu_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);
    `PPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
    `PPU_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !(in_valid && in_ready), "input taken while result pending")
    `PPU_ASSERT_IMPLY(a_excl, clk, rst_n, out_valid, !(out_data.spawn_dropped && out_data.read_valid), "drop and read both set")
    `PPU_ASSERT_IMPLY(a_count, clk, rst_n, out_valid, out_data.alive_count <= 9'd256, "count out of range")
endmodule

bind particle_pool_update_top ppu_checker u_ppu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

/* dv/particle_pool_checker.sv */
`timescale 1ns / 1ps
module particle_pool_checker
    import ppu_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  logic      clk,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_word_t cfg_word,
    output int        waiting,
    output int        errors
);
    typedef struct {
        int          pos[3];
        int          vel[3];
        int          acc[3];
        int          rot;
        int          rate;
        int unsigned age;
        int unsigned life;
        int unsigned drg;
    } particle_t;

    particle_t   pool[POOL_SIZE];
    int unsigned live;
    int          grav[3];
    int unsigned drag_k;
    out_word_t   results_due[$];

    initial begin
        live    = 0;
        grav    = '{0, 0, 0};
        drag_k  = 0;
        waiting = 0;
        errors  = 0;
    end

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    // floor(a*b/65536), b in [0, 65536]
    function automatic longint scale_q16(int a, int unsigned b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic void advance_pool(int unsigned dt);
        int unsigned i;
        longint      aged;
        longint      dd;
        int unsigned f;
        int          v;
        i = 0;
        while (i < live) begin
            aged = longint'(pool[i].age) + longint'(dt);
            pool[i].age = (aged > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : int'(aged);
            if (pool[i].age >= pool[i].life) begin
                // swap-remove; the moved-in particle is handled in this slot
                live--;
                pool[i] = pool[live];
            end
            else begin
                dd = (longint'(pool[i].drg) * longint'(dt)) >>> 16;
                f  = (dd >= 65536) ? 0 : 65536 - int'(dd);
                for (int k = 0; k < 3; k++) begin
                    v = clip32(longint'(pool[i].vel[k]) + scale_q16(pool[i].acc[k], dt));
                    v = clip32(scale_q16(v, f));
                    pool[i].vel[k] = v;
                    pool[i].pos[k] = clip32(longint'(pool[i].pos[k]) + scale_q16(v, dt));
                end
                pool[i].rot = clip32(longint'(pool[i].rot) + scale_q16(pool[i].rate, dt));
                i++;
            end
        end
    endfunction

    function automatic out_word_t predict_pool(in_word_t w);
        out_word_t r;
        r = '0;
        if (w.operation == OP_SPAWN) begin
            if (live >= POOL_SIZE)
                r.spawn_dropped = 1'b1;
            else begin
                pool[live].pos  = '{w.pos_x, w.pos_y, w.pos_z};
                pool[live].vel  = '{w.vel_x, w.vel_y, w.vel_z};
                pool[live].acc  = grav;
                pool[live].rot  = w.start_rotation;
                pool[live].rate = w.angular_rate;
                pool[live].age  = 0;
                pool[live].life = (w.lifetime < MIN_LIFE) ? MIN_LIFE : w.lifetime;
                pool[live].drg  = drag_k;
                live++;
            end
        end
        else if (w.operation == OP_STEP)
            advance_pool(w.time_step);
        else if (w.operation == OP_READ && w.slot < live) begin
            r.read_valid   = 1'b1;
            r.out_pos_x    = pool[w.slot].pos[0];
            r.out_pos_y    = pool[w.slot].pos[1];
            r.out_pos_z    = pool[w.slot].pos[2];
            r.out_vel_x    = pool[w.slot].vel[0];
            r.out_vel_y    = pool[w.slot].vel[1];
            r.out_vel_z    = pool[w.slot].vel[2];
            r.out_rotation = pool[w.slot].rot;
            r.out_age      = pool[w.slot].age[30:0];
        end
        r.alive_count = live[8:0];
        return r;
    endfunction

    task automatic check_field(string tag, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, tag, want, got);
        end
    endtask

    always @(posedge clk) begin
        out_word_t want;
        if (cfg_valid && cfg_ready) begin
            case (cfg_word.index)
                CFG_GX:   grav[0] = cfg_word.data;
                CFG_GY:   grav[1] = cfg_word.data;
                CFG_GZ:   grav[2] = cfg_word.data;
                CFG_DRAG: drag_k  = {1'b0, cfg_word.data[30:0]};
                default:  ;
            endcase
        end
        if (in_valid && in_ready)
            results_due.push_back(predict_pool(in_word));
        if (out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: %p", $time, out_word);
            end
            else begin
                want = results_due.pop_front();
                check_field("alive_count", want.alive_count, out_word.alive_count);
                check_field("spawn_dropped", want.spawn_dropped, out_word.spawn_dropped);
                check_field("read_valid", want.read_valid, out_word.read_valid);
                check_field("out_pos_x", want.out_pos_x, out_word.out_pos_x);
                check_field("out_pos_y", want.out_pos_y, out_word.out_pos_y);
                check_field("out_pos_z", want.out_pos_z, out_word.out_pos_z);
                check_field("out_vel_x", want.out_vel_x, out_word.out_vel_x);
                check_field("out_vel_y", want.out_vel_y, out_word.out_vel_y);
                check_field("out_vel_z", want.out_vel_z, out_word.out_vel_z);
                check_field("out_rotation", want.out_rotation, out_word.out_rotation);
                check_field("out_age", want.out_age, out_word.out_age);
            end
        end
        waiting = results_due.size();
    end
endmodule

/* dv/particle_pool_update_top_tb.sv */
`timescale 1ns / 1ps
module particle_pool_update_top_tb;
    import ppu_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 300;

    logic clk;
    logic rst_n;
    int   idle_pct;
    bit   hold_req;
    int   waiting;
    int   errors;
    int   quiet_cycles;

    ppu_if #(.word_t(in_word_t))  in_ch ();
    ppu_if #(.word_t(out_word_t)) out_ch ();
    ppu_if #(.word_t(cfg_word_t)) cfg ();

    particle_pool_update_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    particle_pool_checker u_checker (
        .clk       (clk),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_word   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_word  (out_ch.data),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_word  (cfg.data),
        .waiting   (waiting),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random backpressure, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else
                out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.data  <= '{index: idx, data: value};
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (waiting != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic load_settings(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                 logic [30:0] dr);
        write_reg(CFG_GX, gx);
        write_reg(CFG_GY, gy);
        write_reg(CFG_GZ, gz);
        write_reg(CFG_DRAG, {1'b0, dr});
    endtask

    // life_mode: 0 short, 1 medium, 2 any, 3 long
    function automatic in_word_t make_word(logic [1:0] op, int life_mode);
        in_word_t w;
        w.operation      = op;
        w.slot           = 8'($urandom);
        w.pos_x          = $urandom;
        w.pos_y          = $urandom;
        w.pos_z          = $urandom;
        w.vel_x          = $urandom;
        w.vel_y          = $urandom;
        w.vel_z          = $urandom;
        w.start_rotation = $urandom;
        w.angular_rate   = $urandom;
        case (life_mode)
            0:       w.lifetime = 31'($urandom_range(0, 20));
            1:       w.lifetime = 31'($urandom_range(65536, 65536 * 8));
            3:       w.lifetime = 31'($urandom_range(1 << 22, 1 << 30));
            default: w.lifetime = 31'($urandom);
        endcase
        case ($urandom_range(9))
            0:       w.time_step = 16'd0;
            1:       w.time_step = 16'hFFFF;
            2:       w.time_step = 16'($urandom_range(1, 64));
            default: w.time_step = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic directed_items();
        in_word_t w;
        send_word(make_word(OP_READ, 2));
        send_word(make_word(OP_STEP, 2));
        send_word(make_word(OP_UNUSED, 2));
        // lifetime below the floor, extreme positions and velocities
        w = make_word(OP_SPAWN, 0);
        w.lifetime = '0;
        {w.pos_x, w.pos_y, w.pos_z} = {3{32'sh7FFF_FFFF}};
        {w.vel_x, w.vel_y, w.vel_z} = {3{32'sh7FFF_FFFF}};
        send_word(w);
        w = make_word(OP_SPAWN, 0);
        w.lifetime = 31'd6;
        {w.pos_x, w.pos_y, w.pos_z} = {3{32'sh8000_0000}};
        {w.vel_x, w.vel_y, w.vel_z} = {3{32'sh8000_0000}};
        send_word(w);
        w = make_word(OP_SPAWN, 0);
        w.lifetime = MIN_LIFE;
        send_word(w);
        w = make_word(OP_SPAWN, 0);
        w.lifetime       = AGE_MAX;
        w.start_rotation = 32'sh7FFF_FFFF;
        w.angular_rate   = 32'sh7FFF_FFFF;
        send_word(w);
        for (int s = 0; s < 5; s++)
        begin
            w = make_word(OP_READ, 0);
            w.slot = 8'(s);
            send_word(w);
        end
        w = make_word(OP_STEP, 0);
        w.time_step = 16'd0;
        send_word(w);
        w.time_step = 16'd1;
        send_word(w);
        w.time_step = 16'hFFFF;
        send_word(w);
        for (int s = 0; s < 3; s++)
        begin
            w = make_word(OP_READ, 0);
            w.slot = 8'(s);
            send_word(w);
        end
        w.slot = 8'hFF;
        send_word(w);
    endtask

    initial
    begin
        int          pick;
        logic [1:0]  op;
        logic [30:0] dr;
        bit          fill;
        rst_n       = 1'b0;
        idle_pct    = 36;
        hold_req    = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg.valid   = 1'b0;
        cfg.data    = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 31'd0);
        directed_items();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       dr = 31'h7FFF_FFFF;
                1:       dr = 31'($urandom_range(0, 1 << 17));
                2:       dr = 31'd0;
                3:       dr = 31'($urandom);
                default: dr = 31'($urandom_range(0, 1 << 18));
            endcase
            if (ph == 4)
                load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, dr);
            else
                load_settings($urandom, $urandom, $urandom, dr);
            idle_pct = (ph == 1) ? 0 : 36;
            fill = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 50)
                    hold_req = 1'b1;
                if (ph == 3 && n == 150)
                    drain_results();
                pick = $urandom_range(99);
                if (fill)
                    op = (pick < 72) ? OP_SPAWN : (pick < 75) ? OP_STEP
                       : (pick < 98) ? OP_READ : OP_UNUSED;
                else
                    op = (pick < 40) ? OP_SPAWN : (pick < 56) ? OP_STEP
                       : (pick < 95) ? OP_READ : OP_UNUSED;
                send_word(make_word(op, fill ? 3 : $urandom_range(0, 2)));
            end
        end

        in_ch.valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
